// ===== rtl/core/lfbm_pkg.sv =====
// package: shared types and constants for the line fill buffer manager
`timescale 1ns / 1ps
package lfbm_pkg;
    localparam int NUM_ENTRIES = 8;
    localparam int MAX_PENDING = 16;
    localparam int BLOCK_BYTES = 64;
    localparam int IDX_W = 3;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam int PEND_W = $clog2(MAX_PENDING + 1);
    localparam int BLK_W = 42;
    localparam int MASK_W = 64;
    localparam int AGE_W = 8;
    localparam logic [MASK_W-1:0] LANE_MASK =
        (BLOCK_BYTES >= 64) ? {MASK_W{1'b1}} : ((64'h1 << BLOCK_BYTES) - 64'h1);

    typedef enum logic [2:0] {
        ST_INVALID = 3'd0, ST_MISSED = 3'd1, ST_DATA_ARRAY = 3'd2,
        ST_FILLED = 3'd3, ST_RETIRED = 3'd4
    } t_est;

    typedef enum logic [2:0] {
        CMD_LOAD = 3'd0, CMD_PREFETCH = 3'd1, CMD_STORE = 3'd2, CMD_FILL = 3'd3,
        CMD_DA_DONE = 3'd4, CMD_SUB_RET = 3'd5, CMD_WR_ISSUED = 3'd6, CMD_NONE = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0, ACT_RETURN = 2'd1, ACT_MEMREQ = 2'd2, ACT_DARRAY = 2'd3
    } t_act;

    localparam logic [0:0] REG_RETIRE = 1'b0;
    localparam logic [0:0] REG_ZERO_LAT = 1'b1;

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_UPDATE } t_fsm;

    // per-entry compare results fed to the scan unit
    typedef struct packed {
        logic live_match;
        logic fill_match;
        logic is_invalid;
        logic is_retired;
    } t_cmp;
endpackage

// ===== rtl/core/lfbm_scan.sv =====
// scan unit: compares one entry per cycle while i_step is high and keeps running picks
`timescale 1ns / 1ps
module lfbm_scan
    import lfbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_clear,
    input  logic             i_step,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cmp             i_cmp,
    input  logic [AGE_W-1:0] i_age,
    output logic             o_live_ok,
    output logic [IDX_W-1:0] o_live_idx,
    output logic             o_fill_ok,
    output logic [IDX_W-1:0] o_fill_idx,
    output logic             o_alloc_ok,
    output logic [IDX_W-1:0] o_alloc_idx
);
    logic r_live_ok, r_fill_ok, r_inv_ok, r_ret_ok;
    logic [IDX_W-1:0] r_live_idx, r_fill_idx, r_inv_idx, r_ret_idx;
    logic [AGE_W-1:0] r_best;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_live_ok <= 1'b0;
            r_fill_ok <= 1'b0;
            r_inv_ok  <= 1'b0;
            r_ret_ok  <= 1'b0;
            r_best    <= '0;
        end else if (i_step) begin
            if (i_cmp.live_match && !r_live_ok) begin
                r_live_ok  <= 1'b1;
                r_live_idx <= i_idx;
            end
            if (i_cmp.fill_match && !r_fill_ok) begin
                r_fill_ok  <= 1'b1;
                r_fill_idx <= i_idx;
            end
            if (i_cmp.is_invalid && !r_inv_ok) begin
                r_inv_ok  <= 1'b1;
                r_inv_idx <= i_idx;
            end
            if (i_cmp.is_retired && !r_inv_ok && i_age >= r_best) begin
                r_ret_ok  <= 1'b1;
                r_ret_idx <= i_idx;
                r_best    <= i_age;
            end
        end
    end

    assign o_live_ok   = r_live_ok;
    assign o_live_idx  = r_live_idx;
    assign o_fill_ok   = r_fill_ok;
    assign o_fill_idx  = r_fill_idx;
    assign o_alloc_ok  = r_inv_ok || r_ret_ok;
    assign o_alloc_idx = r_inv_ok ? r_inv_idx : r_ret_idx;
endmodule

// ===== rtl/core/line_fill_buffer_manager_top.sv =====
// top level: line fill buffer entries, sequencer and result register
//
// channel  dir  ports                                              timing
// cfg      in   i_cfg_we i_cfg_index i_cfg_data                     one cycle
// command  in   i_start (o_busy) i_command i_block_number ...      start && !busy
// result   out  o_done o_entry_index o_stalled o_was_found ...     one-cycle strobe
//
// a command runs one entry compare per cycle
// through the shared scan unit, then the update state, then the result beat
// busy stays high from accept until the result beat; the receiver cannot stall
// reset invalidates all entries at once and restores the register defaults
`timescale 1ns / 1ps
module line_fill_buffer_manager_top
    import lfbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [0:0]        i_cfg_data,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [2:0]        i_command,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic              i_tag_hit,
    input  logic [MASK_W-1:0] i_byte_mask,
    input  logic [2:0]        i_entry_select,
    output logic              o_done,
    output logic [2:0]        o_entry_index,
    output logic              o_stalled,
    output logic              o_was_found,
    output logic [1:0]        o_action,
    output logic              o_entry_drained
);
    logic r_retire, r_zero_lat;
    t_est              r_state [NUM_ENTRIES];
    logic              r_wr    [NUM_ENTRIES];
    logic [BLK_W-1:0]  r_blk   [NUM_ENTRIES];
    logic [AGE_W-1:0]  r_age   [NUM_ENTRIES];
    logic [MASK_W-1:0] r_mask  [NUM_ENTRIES];
    logic [PEND_W-1:0] r_pend  [NUM_ENTRIES];

    t_fsm r_fsm, n_fsm;
    logic [CNT_W-1:0] r_cnt;
    t_cmd r_cmd;
    logic [BLK_W-1:0] r_iblk;
    logic r_hit;
    logic [MASK_W-1:0] r_bm;
    logic [2:0] r_sel;

    logic r_done;
    logic [2:0] r_oidx;
    logic r_ostall, r_ofound, r_odrain;
    t_act r_oact;

    logic [IDX_W-1:0] scan_idx;
    t_cmp cmp;
    logic live_ok, fill_ok, alloc_ok;
    logic [IDX_W-1:0] live_idx, fill_idx, alloc_idx;
    logic accept, step, upd;
    logic is_req, is_wr;

    assign accept = i_start && (r_fsm == S_IDLE);
    assign step   = (r_fsm == S_SCAN);
    assign upd    = (r_fsm == S_UPDATE);
    assign scan_idx = r_cnt[IDX_W-1:0];
    assign is_req = (r_cmd == CMD_LOAD) || (r_cmd == CMD_PREFETCH) || (r_cmd == CMD_STORE);
    assign is_wr  = (r_cmd == CMD_STORE);

    always_comb begin
        cmp.live_match = (r_state[scan_idx] != ST_INVALID) && (r_blk[scan_idx] == r_iblk)
                         && (r_wr[scan_idx] == is_wr);
        cmp.fill_match = (r_state[scan_idx] == ST_MISSED) && !r_wr[scan_idx]
                         && (r_blk[scan_idx] == r_iblk);
        cmp.is_invalid = (r_state[scan_idx] == ST_INVALID);
        cmp.is_retired = (r_state[scan_idx] == ST_RETIRED);
    end

    lfbm_scan u_scan (
        .i_clk(i_clk), .i_clear(accept), .i_step(step), .i_idx(scan_idx),
        .i_cmp(cmp), .i_age(r_age[scan_idx]),
        .o_live_ok(live_ok), .o_live_idx(live_idx),
        .o_fill_ok(fill_ok), .o_fill_idx(fill_idx),
        .o_alloc_ok(alloc_ok), .o_alloc_idx(alloc_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fsm <= S_IDLE;
        else r_fsm <= n_fsm;
    end

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            S_IDLE:   if (i_start) n_fsm = S_SCAN;
            S_SCAN:   if (r_cnt == CNT_W'(NUM_ENTRIES - 1)) n_fsm = S_UPDATE;
            S_UPDATE: n_fsm = S_IDLE;
            default:  n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt  <= '0;
            r_cmd  <= t_cmd'(i_command);
            r_iblk <= i_block_number;
            r_hit  <= i_tag_hit;
            r_bm   <= i_byte_mask & LANE_MASK;
            r_sel  <= i_entry_select;
        end else if (step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // update cycle: apply command to entries and form the result beat
    logic sel_ok;
    logic [IDX_W-1:0] si;
    assign sel_ok = ({1'b0, r_sel} < 4'(NUM_ENTRIES));
    assign si = r_sel[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retire   <= 1'b1;
            r_zero_lat <= 1'b0;
            r_done     <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_state[i] <= ST_INVALID;
                r_wr[i]    <= 1'b0;
                r_blk[i]   <= '0;
                r_age[i]   <= '0;
                r_mask[i]  <= '0;
                r_pend[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_RETIRE) r_retire <= i_cfg_data[0];
                if (i_cfg_index == REG_ZERO_LAT) r_zero_lat <= i_cfg_data[0];
            end
            r_done <= upd;
            if (upd) begin
                r_oidx   <= '0;
                r_ostall <= 1'b0;
                r_ofound <= 1'b0;
                r_oact   <= ACT_NONE;
                r_odrain <= 1'b0;
                if (is_req) begin
                    if (live_ok) begin
                        r_oidx   <= 3'(live_idx);
                        r_ofound <= 1'b1;
                        if (r_cmd == CMD_LOAD && r_pend[live_idx] >= PEND_W'(MAX_PENDING)) begin
                            r_ostall <= 1'b1;
                        end else if (is_wr) begin
                            r_mask[live_idx] <= r_mask[live_idx] | r_bm;
                        end else begin
                            if (r_cmd == CMD_LOAD) r_pend[live_idx] <= r_pend[live_idx] + 1'b1;
                            if (r_state[live_idx] == ST_RETIRED) begin
                                r_state[live_idx] <= ST_FILLED;
                                r_oact <= ACT_RETURN;
                            end
                        end
                    end else if (!alloc_ok) begin
                        r_ostall <= 1'b1;
                    end else begin
                        r_oidx <= 3'(alloc_idx);
                        for (int i = 0; i < NUM_ENTRIES; i++)
                            if (r_age[i] != {AGE_W{1'b1}}) r_age[i] <= r_age[i] + 1'b1;
                        r_age[alloc_idx]  <= '0;
                        r_blk[alloc_idx]  <= r_iblk;
                        r_wr[alloc_idx]   <= is_wr;
                        r_mask[alloc_idx] <= is_wr ? r_bm : '0;
                        r_pend[alloc_idx] <= (r_cmd == CMD_LOAD) ? PEND_W'(1) : '0;
                        if (is_wr) begin
                            r_state[alloc_idx] <= ST_FILLED;
                            r_oact <= ACT_MEMREQ;
                        end else if (!r_hit) begin
                            r_state[alloc_idx] <= ST_MISSED;
                            r_oact <= ACT_MEMREQ;
                        end else if (r_zero_lat) begin
                            r_state[alloc_idx] <= ST_FILLED;
                            r_oact <= ACT_RETURN;
                        end else begin
                            r_state[alloc_idx] <= ST_DATA_ARRAY;
                            r_oact <= ACT_DARRAY;
                        end
                    end
                end else if (r_cmd == CMD_FILL) begin
                    if (fill_ok) begin
                        r_state[fill_idx] <= ST_FILLED;
                        r_oidx   <= 3'(fill_idx);
                        r_ofound <= 1'b1;
                        r_oact   <= ACT_RETURN;
                    end
                end else if (r_cmd != CMD_NONE) begin
                    r_oidx <= r_sel;
                    if (sel_ok) begin
                        case (r_cmd)
                            CMD_DA_DONE: if (r_state[si] == ST_DATA_ARRAY && !r_wr[si]) begin
                                r_state[si] <= ST_FILLED;
                                r_ofound <= 1'b1;
                                r_oact <= ACT_RETURN;
                            end
                            CMD_SUB_RET: if (r_state[si] == ST_FILLED && !r_wr[si]) begin
                                r_ofound <= 1'b1;
                                if (r_pend[si] <= PEND_W'(1)) begin
                                    r_pend[si] <= '0;
                                    r_state[si] <= r_retire ? ST_RETIRED : ST_INVALID;
                                    r_odrain <= 1'b1;
                                end else begin
                                    r_pend[si] <= r_pend[si] - 1'b1;
                                end
                            end
                            CMD_WR_ISSUED: if (r_state[si] == ST_FILLED && r_wr[si]) begin
                                r_state[si] <= ST_INVALID;
                                r_ofound <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    assign o_busy          = (r_fsm != S_IDLE);
    assign o_done          = r_done;
    assign o_entry_index   = r_oidx;
    assign o_stalled       = r_ostall;
    assign o_was_found     = r_ofound;
    assign o_action        = r_oact;
    assign o_entry_drained = r_odrain;

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (r_fsm == S_IDLE) && o_done) else $error("update not followed by result");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(upd)) else $error("result without update");
    a_drain_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_entry_drained |-> o_was_found) else $error("drain without found");
    a_stall_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_stalled |-> o_action == ACT_NONE) else $error("stall with action");
endmodule

// ===== dv/line_fill_buffer_manager_top_tb.sv =====
// testbench for the line fill buffer manager: directed and random commands checked by a predictor
`timescale 1ns / 1ps
module line_fill_buffer_manager_top_tb;
    import lfbm_pkg::*;

    typedef struct packed {
        logic [2:0] idx;
        logic       stalled;
        logic       found;
        logic [1:0] act;
        logic       drained;
    } t_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_index = '0;
    logic [0:0]        i_cfg_data = '0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic [2:0]        i_command = '0;
    logic [BLK_W-1:0]  i_block_number = '0;
    logic              i_tag_hit = 1'b0;
    logic [MASK_W-1:0] i_byte_mask = '0;
    logic [2:0]        i_entry_select = '0;
    logic              o_done;
    logic [2:0]        o_entry_index;
    logic              o_stalled;
    logic              o_was_found;
    logic [1:0]        o_action;
    logic              o_entry_drained;

    line_fill_buffer_manager_top dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic                 retire_cfg;
    logic                 zero_lat_cfg;
    t_est                 ent_st[NUM_ENTRIES];
    logic                 ent_wr[NUM_ENTRIES];
    logic [BLK_W-1:0]     ent_blk[NUM_ENTRIES];
    logic [AGE_W-1:0]     ent_age[NUM_ENTRIES];
    logic [MASK_W-1:0]    ent_mask[NUM_ENTRIES];
    logic [PEND_W-1:0]    ent_pend[NUM_ENTRIES];

    t_res    expected_beats[$];
    int      mismatches = 0;
    int      beats_seen = 0;
    int      cycles = 0;
    int      stalls_seen = 0;
    int      drains_seen = 0;
    logic [BLK_W-1:0] blk_pool[4];

    function automatic t_res predict_command(t_cmd cmd, logic [BLK_W-1:0] blk, logic hit,
                                             logic [MASK_W-1:0] bmask, logic [2:0] sel);
        t_res r;
        int   s;
        int   pick;
        logic wr;
        logic fresh;
        logic [AGE_W-1:0] best;
        r = '0;
        s = -1;
        pick = -1;
        fresh = 1'b0;
        best = '0;
        wr = (cmd == CMD_STORE);
        case (cmd)
            CMD_LOAD, CMD_PREFETCH, CMD_STORE: begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (s < 0 && ent_st[i] != ST_INVALID && ent_blk[i] == blk && ent_wr[i] == wr)
                        s = i;
                if (s >= 0) begin
                    r.found = 1'b1;
                    r.idx = s[2:0];
                    if (cmd == CMD_LOAD && ent_pend[s] >= MAX_PENDING) begin
                        r.stalled = 1'b1;
                        return r;
                    end
                end else begin
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (ent_st[i] == ST_INVALID) begin
                            pick = i;
                            break;
                        end
                        if (ent_st[i] == ST_RETIRED && ent_age[i] >= best) begin
                            best = ent_age[i];
                            pick = i;
                        end
                    end
                    if (pick < 0) begin
                        r.stalled = 1'b1;
                        return r;
                    end
                    for (int i = 0; i < NUM_ENTRIES; i++)
                        if (ent_age[i] != 8'hff) ent_age[i]++;
                    s = pick;
                    ent_age[s] = '0;
                    ent_blk[s] = blk;
                    ent_wr[s] = wr;
                    ent_mask[s] = '0;
                    ent_pend[s] = '0;
                    ent_st[s] = ST_INVALID;
                    r.idx = s[2:0];
                    fresh = 1'b1;
                end
                if (wr) begin
                    ent_mask[s] |= bmask & LANE_MASK;
                    if (fresh) begin
                        ent_st[s] = ST_FILLED;
                        r.act = ACT_MEMREQ;
                    end
                end else begin
                    if (cmd == CMD_LOAD) ent_pend[s]++;
                    if (fresh) begin
                        if (hit && zero_lat_cfg) begin
                            ent_st[s] = ST_FILLED;
                            r.act = ACT_RETURN;
                        end else if (hit) begin
                            ent_st[s] = ST_DATA_ARRAY;
                            r.act = ACT_DARRAY;
                        end else begin
                            ent_st[s] = ST_MISSED;
                            r.act = ACT_MEMREQ;
                        end
                    end else if (ent_st[s] == ST_RETIRED) begin
                        ent_st[s] = ST_FILLED;
                        r.act = ACT_RETURN;
                    end
                end
            end
            CMD_FILL: begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (ent_st[i] == ST_MISSED && !ent_wr[i] && ent_blk[i] == blk) begin
                        ent_st[i] = ST_FILLED;
                        r.idx = i[2:0];
                        r.found = 1'b1;
                        r.act = ACT_RETURN;
                        break;
                    end
                end
            end
            CMD_DA_DONE: begin
                r.idx = sel;
                if (ent_st[sel] == ST_DATA_ARRAY && !ent_wr[sel]) begin
                    ent_st[sel] = ST_FILLED;
                    r.found = 1'b1;
                    r.act = ACT_RETURN;
                end
            end
            CMD_SUB_RET: begin
                r.idx = sel;
                if (ent_st[sel] == ST_FILLED && !ent_wr[sel]) begin
                    r.found = 1'b1;
                    if (ent_pend[sel] != 0) ent_pend[sel]--;
                    if (ent_pend[sel] == 0) begin
                        ent_st[sel] = retire_cfg ? ST_RETIRED : ST_INVALID;
                        r.drained = 1'b1;
                    end
                end
            end
            CMD_WR_ISSUED: begin
                r.idx = sel;
                if (ent_st[sel] == ST_FILLED && ent_wr[sel]) begin
                    ent_st[sel] = ST_INVALID;
                    r.found = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_command(t_cmd cmd, logic [BLK_W-1:0] blk, logic hit,
                                logic [MASK_W-1:0] bmask, logic [2:0] sel);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        i_start <= 1'b1;
        i_command <= cmd;
        i_block_number <= blk;
        i_tag_hit <= hit;
        i_byte_mask <= bmask;
        i_entry_select <= sel;
        @(posedge i_clk);
        expected_beats.push_back(predict_command(cmd, blk, hit, bmask, sel));
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic drain_results;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (NUM_ENTRIES + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_RETIRE) retire_cfg = val;
        else zero_lat_cfg = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            got = {o_entry_index, o_stalled, o_was_found, o_action, o_entry_drained};
            beats_seen++;
            if (got.stalled) stalls_seen++;
            if (got.drained) drains_seen++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: got %p", got);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("beat mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    function automatic logic [BLK_W-1:0] pick_block();
        if ($urandom_range(0, 9) < 8) return blk_pool[$urandom_range(0, 3)];
        return BLK_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed;
        send_command(CMD_LOAD, '0, 1'b0, '0, 3'd0);
        send_command(CMD_LOAD, '1, 1'b1, '1, 3'd7);
        send_command(CMD_PREFETCH, 42'h155_5555_5555, 1'b1, '0, 3'd0);
        send_command(CMD_STORE, 42'h2aa_aaaa_aaaa, 1'b0, '1, 3'd0);
        send_command(CMD_STORE, 42'h2aa_aaaa_aaaa, 1'b0, 64'h5555_5555_5555_5555, 3'd0);
        send_command(CMD_FILL, '0, 1'b0, '0, 3'd0);
        send_command(CMD_FILL, 42'h123, 1'b0, '0, 3'd0);
        send_command(CMD_DA_DONE, '0, 1'b0, '0, 3'd1);
        send_command(CMD_DA_DONE, '0, 1'b0, '0, 3'd2);
        send_command(CMD_SUB_RET, '0, 1'b0, '0, 3'd0);
        send_command(CMD_SUB_RET, '0, 1'b0, '0, 3'd1);
        send_command(CMD_WR_ISSUED, '0, 1'b0, '0, 3'd3);
        send_command(CMD_WR_ISSUED, '0, 1'b0, '0, 3'd3);
        send_command(CMD_NONE, '1, 1'b1, '1, 3'd7);
        // reuse retired entry
        send_command(CMD_LOAD, '0, 1'b0, '0, 3'd0);
        // pending list full
        for (int i = 0; i < 17; i++) send_command(CMD_LOAD, '1, 1'b0, '0, 3'd0);
        drain_results();
    endtask

    task automatic test_no_free_entry;
        for (int i = 0; i < 10; i++)
            send_command(CMD_LOAD, 42'h1000 + BLK_W'(i), 1'b0, '0, 3'd0);
        drain_results();
    endtask

    task automatic test_random(int count);
        t_cmd cmd;
        int   k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 25) cmd = CMD_LOAD;
            else if (k < 32) cmd = CMD_PREFETCH;
            else if (k < 42) cmd = CMD_STORE;
            else if (k < 56) cmd = CMD_FILL;
            else if (k < 66) cmd = CMD_DA_DONE;
            else if (k < 88) cmd = CMD_SUB_RET;
            else if (k < 97) cmd = CMD_WR_ISSUED;
            else cmd = CMD_NONE;
            send_command(cmd, pick_block(), 1'($urandom_range(0, 1)), rand_mask(),
                         3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        retire_cfg = 1'b1;
        zero_lat_cfg = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            ent_st[i] = ST_INVALID;
            ent_wr[i] = 1'b0;
            ent_blk[i] = '0;
            ent_age[i] = '0;
            ent_mask[i] = '0;
            ent_pend[i] = '0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        test_directed();
        test_no_free_entry();
        for (int ph = 0; ph < 4; ph++) begin
            for (int b = 0; b < 4; b++) blk_pool[b] = BLK_W'({$urandom(), $urandom()});
            if (ph == 0) blk_pool[0] = '1;
            write_reg(REG_RETIRE, ph[0]);
            write_reg(REG_ZERO_LAT, ph[1]);
            test_random(240);
            drain_results();
            test_random(240);
            drain_results();
        end
        $display("covered %0d beats, %0d stalls and %0d drains", beats_seen, stalls_seen,
                 drains_seen);
        $display("all four register settings and every command were exercised");
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end
endmodule
